>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL; clocked on clk, disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational check sampled at every rising clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that holds in the cycle after the trigger.
`define ASSERT_NEXT(label, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error(msg);

`endif

>>> rtl/udpcv_pkg.sv
// Package for the UDP checksum validator: word types, codes and constants.
package udpcv_pkg;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SHORT    = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;

	localparam logic OP_VERIFY   = 1'b0;
	localparam logic OP_GENERATE = 1'b1;

	localparam logic [15:0] UDP_PROTO     = 16'h0011;
	localparam logic [15:0] HDR_BYTES     = 16'd8;
	localparam logic [15:0] CSUM_ZERO_ALT = 16'hFFFF;
	localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

	typedef struct packed {
		logic        op;
		logic [7:0]  data_byte;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic        last;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] checksum_value;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] body_len;
	} out_t;

	// datagram summary handed from the byte parser to the checksum finisher
	typedef struct packed {
		logic        op;
		logic [15:0] count;
		logic [15:0] hdr_len;
		logic [15:0] hdr_csum;
		logic [31:0] port_pair;
		logic [7:0]  held;
		logic [15:0] run_sum;
		logic [18:0] addr_sum;
	} fin_t;

endpackage

>>> rtl/udpcv_frame.sv
// Byte parser: header capture, payload word accumulation, datagram summary on last byte.
module udpcv_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              item_valid_s1,
	input  udpcv_pkg::in_t    item_s1,
	output logic              fin_valid_s2,
	output udpcv_pkg::fin_t   fin_s2
);
	import udpcv_pkg::*;

	logic [15:0] byte_count_q;
	logic [15:0] run_sum_q;
	logic [7:0]  held_q;
	logic [15:0] hdr_len_q;
	logic [15:0] hdr_csum_q;
	logic [31:0] port_pair_q;
	logic [18:0] addr_sum_q;

	logic [15:0] count_d;
	logic [15:0] run_sum_d;
	logic [7:0]  held_d;
	logic [15:0] hdr_len_d;
	logic [15:0] hdr_csum_d;
	logic [31:0] port_pair_d;
	logic [18:0] addr_sum_d;
	logic [16:0] add_t;
	logic [7:0]  b;
	logic        take;
	fin_t        fin_d;

	assign b    = item_s1.data_byte;
	assign take = adv && item_valid_s1;

	always_comb begin
		run_sum_d   = run_sum_q;
		held_d      = held_q;
		hdr_len_d   = hdr_len_q;
		hdr_csum_d  = hdr_csum_q;
		port_pair_d = port_pair_q;
		addr_sum_d  = addr_sum_q;
		add_t       = {1'b0, run_sum_q} + {1'b0, held_q, b};

		if (byte_count_q == 16'd0) begin
			addr_sum_d = {3'b000, item_s1.src_addr[31:16]} + {3'b000, item_s1.src_addr[15:0]}
				+ {3'b000, item_s1.dst_addr[31:16]} + {3'b000, item_s1.dst_addr[15:0]}
				+ {3'b000, UDP_PROTO};
		end

		if (byte_count_q < 16'd4) begin
			port_pair_d = {port_pair_q[23:0], b};
		end else if (byte_count_q < 16'd6) begin
			hdr_len_d = {hdr_len_q[7:0], b};
		end else if (byte_count_q < HDR_BYTES) begin
			hdr_csum_d = {hdr_csum_q[7:0], b};
		end else if (byte_count_q < hdr_len_q) begin
			if (!byte_count_q[0]) begin
				held_d = b;
			end else begin
				// end-around carry; one fold is enough for two 16-bit operands
				run_sum_d = add_t[15:0] + {15'd0, add_t[16]};
			end
		end

		count_d = (byte_count_q == COUNT_MAX) ? byte_count_q : byte_count_q + 16'd1;

		fin_d.op        = item_s1.op;
		fin_d.count     = count_d;
		fin_d.hdr_len   = hdr_len_d;
		fin_d.hdr_csum  = hdr_csum_d;
		fin_d.port_pair = port_pair_d;
		fin_d.held      = held_d;
		fin_d.run_sum   = run_sum_d;
		fin_d.addr_sum  = addr_sum_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			run_sum_q    <= '0;
			fin_valid_s2 <= 1'b0;
		end else if (adv) begin
			fin_valid_s2 <= take && item_s1.last;
			if (take) begin
				if (item_s1.last) begin
					byte_count_q <= '0;
					run_sum_q    <= '0;
				end else begin
					byte_count_q <= count_d;
					run_sum_q    <= run_sum_d;
				end
			end
		end
	end

	// header fields are fully rewritten by every datagram before use
	always_ff @(posedge clk) begin
		if (take) begin
			held_q      <= held_d;
			hdr_len_q   <= hdr_len_d;
			hdr_csum_q  <= hdr_csum_d;
			port_pair_q <= port_pair_d;
			addr_sum_q  <= addr_sum_d;
			fin_s2      <= fin_d;
		end
	end

endmodule

>>> rtl/udpcv_final.sv
// Checksum finisher: pseudo-header and header terms summed, then folded and checked.
module udpcv_final (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             fin_valid_s2,
	input  udpcv_pkg::fin_t  fin_s2,
	output logic             res_valid_s3,
	output udpcv_pkg::out_t  res
);
	import udpcv_pkg::*;

	typedef struct packed {
		logic        op;
		logic        short_frame;
		logic [15:0] hdr_csum;
		logic [31:0] port_pair;
		logic [15:0] plen;
		logic [19:0] sum;
	} sum_t;

	logic [15:0] len;
	logic [15:0] t0;
	logic [15:0] t1;
	logic [15:0] t2;
	logic [15:0] th;
	sum_t        sum_d;
	sum_t        sum_s3;
	logic [16:0] f1;
	logic [15:0] f2;
	logic [15:0] csum;

	always_comb begin
		len = (fin_s2.hdr_len < fin_s2.count) ? fin_s2.hdr_len : fin_s2.count;

		if (len >= 16'd2) t0 = fin_s2.port_pair[31:16];
		else if (len == 16'd1) t0 = {fin_s2.port_pair[31:24], 8'h00};
		else t0 = '0;

		if (len >= 16'd4) t1 = fin_s2.port_pair[15:0];
		else if (len == 16'd3) t1 = {fin_s2.port_pair[15:8], 8'h00};
		else t1 = '0;

		if (len >= 16'd6) t2 = fin_s2.hdr_len;
		else if (len == 16'd5) t2 = {fin_s2.hdr_len[15:8], 8'h00};
		else t2 = '0;

		th = (len[0] && len > HDR_BYTES) ? {fin_s2.held, 8'h00} : 16'd0;

		sum_d.op          = fin_s2.op;
		sum_d.short_frame = fin_s2.count < HDR_BYTES;
		sum_d.hdr_csum    = fin_s2.hdr_csum;
		sum_d.port_pair   = fin_s2.port_pair;
		sum_d.plen        = fin_s2.count - HDR_BYTES;
		sum_d.sum         = {4'd0, fin_s2.run_sum} + {4'd0, t0} + {4'd0, t1} + {4'd0, t2}
			+ {4'd0, th} + {4'd0, len} + {1'b0, fin_s2.addr_sum};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s3 <= 1'b0;
		end else if (adv) begin
			res_valid_s3 <= fin_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fin_valid_s2) begin
			sum_s3 <= sum_d;
		end
	end

	always_comb begin
		f1   = {1'b0, sum_s3.sum[15:0]} + {13'd0, sum_s3.sum[19:16]};
		f2   = f1[15:0] + {15'd0, f1[16]};
		csum = ~f2;
		if (csum == 16'd0) begin
			csum = CSUM_ZERO_ALT;
		end

		if (sum_s3.short_frame) begin
			res.status         = ST_SHORT;
			res.checksum_value = '0;
			res.src_port       = '0;
			res.dst_port       = '0;
			res.body_len       = '0;
		end else begin
			if (sum_s3.op == OP_VERIFY && sum_s3.hdr_csum != 16'd0 && sum_s3.hdr_csum != csum) begin
				res.status = ST_MISMATCH;
			end else begin
				res.status = ST_OK;
			end
			res.checksum_value = csum;
			res.src_port       = sum_s3.port_pair[31:16];
			res.dst_port       = sum_s3.port_pair[15:0];
			res.body_len       = sum_s3.plen;
		end
	end

endmodule

>>> rtl/udp_checksum_validator.sv
// Top level of the UDP checksum validator: input skid, pipeline and result register.
//
// Input channel (data_valid, data_stall, data): one datagram byte per word in wire
// order, with the IPv4 addresses (taken on the first byte), op and a last-byte mark.
// Output channel (result_valid, result_stall, result): one word per datagram, sent
// for the word that carries last; status, checksum, ports and payload length.
// Throughput: one byte per cycle unless the receiver stalls, back to back, also
// across datagram boundaries. The last byte passes the input register, byte parser,
// sum stage and fold stage into the result register.
// The per-byte path is a 16-bit end-around-carry add; the final sum is one
// multi-operand 20-bit add, then a two-step fold and compare in the next stage.
// When the receiver stalls, the whole pipeline holds; one more input word is
// caught in a skid register and data_stall rises the cycle after, so data_stall is
// a register output. Reset clears the byte count, the running sum and all valids;
// the next byte after reset starts a new datagram.
`include "assert_macros.svh"

module udp_checksum_validator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             data_valid,
	output logic             data_stall,
	input  udpcv_pkg::in_t   data,
	output logic             result_valid,
	input  logic             result_stall,
	output udpcv_pkg::out_t  result
);
	import udpcv_pkg::*;

	logic  adv;
	in_t   skid_q;
	logic  skid_valid_q;
	in_t   head;
	logic  head_valid;
	in_t   item_s1;
	logic  item_valid_s1;
	fin_t  fin_s2;
	logic  fin_valid_s2;
	out_t  res;
	logic  res_valid_s3;
	out_t  result_q;
	logic  result_valid_q;

	assign adv          = !(result_valid_q && result_stall);
	assign data_stall   = skid_valid_q;
	assign head         = skid_valid_q ? skid_q : data;
	assign head_valid   = skid_valid_q || data_valid;
	assign result       = result_q;
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q   <= 1'b0;
			item_valid_s1  <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			skid_valid_q   <= 1'b0;
			item_valid_s1  <= head_valid;
			result_valid_q <= res_valid_s3;
		end else if (data_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && data_valid && !skid_valid_q) begin
			skid_q <= data;
		end
		if (adv) begin
			item_s1  <= head;
			result_q <= res;
		end
	end

	udpcv_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.fin_valid_s2  (fin_valid_s2),
		.fin_s2        (fin_s2)
	);

	udpcv_final u_final (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.fin_valid_s2 (fin_valid_s2),
		.fin_s2       (fin_s2),
		.res_valid_s3 (res_valid_s3),
		.res          (res)
	);

	`ASSERT_NEXT(a_skid_fill, data_valid && !data_stall && !adv, skid_valid_q, "skid word dropped")
	`ASSERT_NEXT(a_skid_drain, skid_valid_q && adv, !skid_valid_q, "skid not drained")
	`ASSERT_ALWAYS(a_result_src, !$rose(result_valid) || $past(res_valid_s3), "result without source")

endmodule

>>> test/udp_checksum_checker.sv
`timescale 1ns / 1ps
// Checker for the UDP checksum validator: tracks each datagram, predicts and compares result words.
module udp_checksum_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            data_valid,
	input  logic            data_stall,
	input  udpcv_pkg::in_t  data,
	input  logic            result_valid,
	input  logic            result_stall,
	input  udpcv_pkg::out_t result,
	output int              errors,
	output int              pending,
	output int              words_in,
	output int              words_out
);
	import udpcv_pkg::*;

	logic [16:0] run_sum;
	logic [15:0] byte_cnt;
	logic [7:0]  held;
	logic [15:0] hdr_len;
	logic [15:0] hdr_csum;
	logic [31:0] ports;
	logic [63:0] addrs;
	out_t        want;
	out_t        result_q[$];

	function automatic logic [16:0] ones_add(input logic [16:0] s, input logic [15:0] w);
		logic [31:0] t;
		t = 32'(s) + 32'(w);
		t = {16'd0, t[15:0]} + (t >> 16);
		t = {16'd0, t[15:0]} + (t >> 16);
		return t[16:0];
	endfunction

	function automatic out_t close_datagram(input logic op);
		out_t        r;
		logic [15:0] span;
		logic [15:0] hw[3];
		logic [16:0] s;
		r = '0;
		if (byte_cnt < HDR_BYTES) begin
			r.status = ST_SHORT;
			return r;
		end
		span = (hdr_len < byte_cnt) ? hdr_len : byte_cnt;
		hw[0] = ports[31:16];
		hw[1] = ports[15:0];
		hw[2] = hdr_len;
		s = run_sum;
		for (int k = 0; k < 3; k++) begin
			if (span >= 2 * k + 2)
				s = ones_add(s, hw[k]);
			else if (span == 2 * k + 1)
				s = ones_add(s, {hw[k][15:8], 8'h00});
		end
		if (span[0] && span > HDR_BYTES)
			s = ones_add(s, {held, 8'h00});
		s = ones_add(s, addrs[63:48]);
		s = ones_add(s, addrs[47:32]);
		s = ones_add(s, addrs[31:16]);
		s = ones_add(s, addrs[15:0]);
		s = ones_add(s, UDP_PROTO);
		s = ones_add(s, span);
		r.checksum_value = ~s[15:0];
		if (r.checksum_value == 16'd0)
			r.checksum_value = CSUM_ZERO_ALT;
		if (op == OP_VERIFY && hdr_csum != 16'd0 && hdr_csum != r.checksum_value)
			r.status = ST_MISMATCH;
		else
			r.status = ST_OK;
		r.src_port = ports[31:16];
		r.dst_port = ports[15:0];
		r.body_len = byte_cnt - HDR_BYTES;
		return r;
	endfunction

	task automatic clear_datagram();
		run_sum = '0;
		byte_cnt = '0;
		held = '0;
		hdr_len = '0;
		hdr_csum = '0;
		ports = '0;
		addrs = '0;
	endtask

	task automatic take_byte(input in_t w);
		logic [15:0] i;
		i = byte_cnt;
		words_in++;
		if (i == 16'd0)
			addrs = {w.src_addr, w.dst_addr};
		if (i < 16'd4)
			ports = {ports[23:0], w.data_byte};
		else if (i < 16'd6)
			hdr_len = {hdr_len[7:0], w.data_byte};
		else if (i < HDR_BYTES)
			hdr_csum = {hdr_csum[7:0], w.data_byte};
		else if (i < hdr_len) begin
			if (!i[0])
				held = w.data_byte;
			else
				run_sum = ones_add(run_sum, {held, w.data_byte});
		end
		if (byte_cnt != COUNT_MAX)
			byte_cnt++;
		if (w.last) begin
			result_q.push_back(close_datagram(w.op));
			clear_datagram();
		end
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
		errors++;
		if (errors <= 40)
			$display("mismatch at %0t ns: %s got %h want %h", $time, what, got, exp_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_datagram();
			result_q.delete();
			errors = 0;
			pending = 0;
			words_in = 0;
			words_out = 0;
		end else begin
			if (result_valid && !result_stall) begin
				words_out++;
				if (result_q.size() == 0) begin
					report("result word with nothing expected", 32'(result.status), 32'd0);
				end else begin
					want = result_q.pop_front();
					if (result.status !== want.status)
						report("status", 32'(result.status), 32'(want.status));
					if (result.checksum_value !== want.checksum_value)
						report("checksum_value", 32'(result.checksum_value),
							32'(want.checksum_value));
					if (result.src_port !== want.src_port)
						report("src_port", 32'(result.src_port), 32'(want.src_port));
					if (result.dst_port !== want.dst_port)
						report("dst_port", 32'(result.dst_port), 32'(want.dst_port));
					if (result.body_len !== want.body_len)
						report("body_len", 32'(result.body_len), 32'(want.body_len));
				end
			end
			if (data_valid && !data_stall)
				take_byte(data);
			pending = result_q.size();
		end
	end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the UDP checksum validator: clock, reset, datagram stimulus and verdict.
module testbench;
	import udpcv_pkg::*;

	localparam int LIMIT        = 1_000_000;
	localparam int RANDOM_WORDS = 1600;

	typedef logic [7:0] byte_q_t[$];

	logic clk;
	logic arst_n;
	logic data_valid;
	logic data_stall;
	in_t  data;
	logic result_valid;
	logic result_stall;
	out_t result;
	logic in_took;
	logic out_took;
	logic quiet;
	int   errors;
	int   pending;
	int   words_in;
	int   words_out;
	int   cycles;
	int   sent;

	udp_checksum_validator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data         (data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	udp_checksum_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data         (data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.errors       (errors),
		.pending      (pending),
		.words_in     (words_in),
		.words_out    (words_out)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_took <= 1'b0;
			out_took <= 1'b0;
		end else begin
			in_took <= data_valid && !data_stall;
			out_took <= result_valid && !result_stall;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: random stall before each result word, none in quiet stretches
	initial begin
		int hold;
		result_stall = 1'b0;
		@(negedge clk);
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 14);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(negedge clk); while (!out_took);
		end
	end

	function automatic byte_q_t frame_bytes(input int n, input logic [15:0] sport, dport,
		hlen, csum);
		byte_q_t     b;
		logic [63:0] hdr;
		hdr = {sport, dport, hlen, csum};
		for (int k = 0; k < n; k++)
			b.push_back(k < 8 ? hdr[63 - 8 * k -: 8] : 8'($urandom));
		return b;
	endfunction

	// plain RFC 768 sum over pseudo-header and span bytes, checksum field as zero
	function automatic logic [15:0] wire_csum(input byte_q_t b, input logic [31:0] src, dst,
		input int span);
		logic [31:0] acc;
		logic [15:0] w;
		acc = 32'(src[31:16]) + 32'(src[15:0]) + 32'(dst[31:16]) + 32'(dst[15:0]) +
			32'(UDP_PROTO) + 32'(span[15:0]);
		for (int k = 0; k < span; k += 2) begin
			w = {b[k], (k + 1 < span) ? b[k + 1] : 8'h00};
			if (k != 6)
				acc += 32'(w);
		end
		while (acc[31:16] != 16'd0)
			acc = 32'(acc[15:0]) + 32'(acc[31:16]);
		w = ~acc[15:0];
		return (w == 16'd0) ? CSUM_ZERO_ALT : w;
	endfunction

	task automatic push_word(input in_t w, input int gap);
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_valid <= 1'b1;
		data <= w;
		do @(negedge clk); while (!in_took);
		sent++;
	endtask

	task automatic send_datagram(input byte_q_t b, input logic op, input logic [31:0] src, dst,
		input bit burst);
		in_t w;
		foreach (b[k]) begin
			w.op = (k == b.size() - 1) ? op : 1'($urandom);
			w.data_byte = b[k];
			w.src_addr = (k == 0) ? src : $urandom;
			w.dst_addr = (k == 0) ? dst : $urandom;
			w.last = (k == b.size() - 1);
			push_word(w, (burst || quiet) ? 0 : $urandom_range(0, 14));
		end
	endtask

	task automatic drain();
		data_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	initial begin
		byte_q_t     b;
		int          n;
		int          kind;
		int          start;
		logic [15:0] hlen;
		logic [15:0] c;
		logic [31:0] src;
		logic [31:0] dst;
		logic        op;

		arst_n = 1'b0;
		data_valid = 1'b0;
		data = '0;
		quiet = 1'b0;
		sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single byte, too short
		b = frame_bytes(1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_datagram(b, OP_VERIFY, 32'h0, 32'h0, 1'b0);
		// seven bytes of all ones in generate mode, still too short
		b = frame_bytes(7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_datagram(b, OP_GENERATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		// bare header, zero checksum skips the check
		b = frame_bytes(8, 16'hFFFF, 16'h0000, 16'h0008, 16'h0000);
		send_datagram(b, OP_VERIFY, $urandom, $urandom, 1'b0);
		// length field below header size, trailing bytes not summed
		b = frame_bytes(9, 16'($urandom), 16'($urandom), 16'h0003, 16'($urandom));
		send_datagram(b, OP_GENERATE, $urandom, $urandom, 1'b0);
		// good checksum with odd payload byte
		src = 32'hFFFF_FFFF;
		dst = 32'hFFFF_FFFF;
		b = frame_bytes(11, 16'($urandom), 16'($urandom), 16'd11, 16'h0000);
		c = wire_csum(b, src, dst, 11);
		b[6] = c[15:8];
		b[7] = c[7:0];
		send_datagram(b, OP_VERIFY, src, dst, 1'b0);
		// length field beyond the received bytes, sent back to back
		b = frame_bytes(9, 16'($urandom), 16'($urandom), 16'hFFFF, 16'h1234);
		send_datagram(b, OP_VERIFY, $urandom, $urandom, 1'b1);
		drain();

		start = sent;
		while (sent < start + RANDOM_WORDS) begin
			quiet = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 19) == 0)
				drain();
			kind = $urandom_range(0, 19);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 200) : $urandom_range(8, 32);
			src = $urandom;
			dst = $urandom;
			op = OP_VERIFY;
			hlen = 16'(n);
			case (kind)
				0: begin
					n = $urandom_range(1, 7);
					op = 1'($urandom);
				end
				1, 2: hlen = 16'($urandom_range(0, n));
				3: hlen = 16'($urandom_range(n, 65535));
				4, 5: op = OP_GENERATE;
				default: ;
			endcase
			b = frame_bytes(n, 16'($urandom), 16'($urandom), hlen,
				(kind >= 6 && kind <= 9) ? 16'($urandom) : 16'h0000);
			if (kind == 10)
				b = frame_bytes(n, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
			if (kind >= 11 || kind == 1 || kind == 3) begin
				c = wire_csum(b, src, dst, (int'(hlen) < n) ? int'(hlen) : n);
				b[6] = c[15:8];
				b[7] = c[7:0];
				if (kind == 19 && n > 8)
					b[$urandom_range(8, n - 1)] ^= 8'(1 << $urandom_range(0, 7));
			end
			send_datagram(b, op, src, dst, 1'b0);
		end

		quiet = 1'b0;
		drain();
		repeat (8) @(negedge clk);

		$display("covered %0d input words and %0d result words, short, odd, cut and", words_in,
			words_out);
		$display("overlong datagrams in both modes, with good, bad and skipped checksums");
		if (errors == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
